>>> hw/rtl/bba_pkg.sv
// bba_pkg: shared types, codes and a helper function for the buddy block allocator
// no dependencies; used by bba_decode, buddy_block_allocator_core and the testbench
package bba_pkg;

  // fixed widths of internal level and offset values
  localparam int OFF_W  = 16;
  localparam int RL_W   = 4;
  localparam int CODE_W = 4;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;

  // configuration register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  // input word
  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [31:0] free_address;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [15:0] used_bytes;
    logic [15:0] free_bytes;
  } out_word_t;

  // pool geometry derived from the managed byte count
  typedef struct packed {
    logic            ok;
    logic [RL_W-1:0] plog;
    logic [RL_W-1:0] pspan;
  } pool_t;

  // decoded request
  typedef struct packed {
    logic             alloc_fail;
    logic [RL_W-1:0]  alloc_rl;
    logic             free_bad;
    logic [OFF_W-1:0] free_off;
  } dec_t;

  // position of the highest set bit, zero for zero
  function automatic logic [4:0] msb32(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) r = 5'(k);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/buddy_block_allocator_core.sv
// buddy_block_allocator_core: binary buddy allocator over a pool of 2^P bytes at base_address.
// Depends on bba_pkg and bba_decode. The buddy tree is kept in a node memory where each node holds
// a mask of the levels that are free somewhere in its subtree, plus a per-granule level table.
// An allocation reads the root, picks the smallest free level, walks down one level a cycle
// toward the lowest-address free block, walks on to the split block one level a cycle, then
// writes masks back up to the root through S_ASC and S_ASCR for each level. SPAN, the tree depth
// of the largest pool (its log2 minus log2 granule), is 11 at the defaults. A free checks the
// level table, then climbs through S_MRG and S_MRGR, merging with free buddies on the way, and
// writes masks back up to the root after. Items are handled one at a time; the next word can be
// taken in the cycle after the result word is registered, and a stalled result word holds the
// next result in S_DONE until it leaves. After reset and after every configuration write a
// clearing pass sweeps the node memory, during which no word is accepted.
module buddy_block_allocator_core #(
  parameter int LEVELS       = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  bba_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output bba_pkg::out_word_t  out_word
);

  localparam int RW       = bba_pkg::RL_W;
  localparam int CW       = bba_pkg::CODE_W;
  localparam int MIN_LOG  = $clog2(HEADER_BYTES);
  localparam int TOP_LOG  = (LEVELS - 1 < 15) ? LEVELS - 1 : 15;
  localparam int SPAN     = TOP_LOG - MIN_LOG;
  localparam int GRANULES = 1 << SPAN;
  localparam int NODES    = (2 << SPAN) - 1;
  localparam int NAW      = SPAN + 1;
  localparam int GAW      = SPAN;
  localparam int MW       = SPAN + 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_PICK  = 11'b00000000100,
    S_DSEL  = 11'b00000001000,
    S_SPLIT = 11'b00000010000,
    S_ASC   = 11'b00000100000,
    S_ASCR  = 11'b00001000000,
    S_GCHK  = 11'b00010000000,
    S_MRG   = 11'b00100000000,
    S_MRGR  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t             state;
  logic [NAW-1:0]     cnt;
  logic [NAW-1:0]     n;
  logic [RW-1:0]      d;
  logic [RW-1:0]      d_top;
  logic [RW-1:0]      d_blk;
  logic [RW-1:0]      t_rl;
  logic [RW-1:0]      rl_req;
  logic [MW-1:0]      m;
  logic               is_alloc;
  logic [GAW-1:0]     g_idx;
  logic [1:0]         status;
  logic [31:0]        addr;
  logic [15:0]        used;
  logic [31:0]        base_address;
  logic [15:0]        managed_bytes;

  bba_pkg::pool_t     pool;
  bba_pkg::dec_t      dec;

  // memory ports
  logic               n_re;
  logic [NAW-1:0]     n_raddr;
  logic [MW-1:0]      nrd;
  logic               n_we;
  logic [NAW-1:0]     n_waddr;
  logic [MW-1:0]      n_wdata;
  logic               g_re;
  logic [GAW-1:0]     g_raddr;
  logic [CW-1:0]      grd;
  logic               g_we;
  logic [GAW-1:0]     g_waddr;
  logic [CW-1:0]      g_wdata;

  // helpers
  logic [RW-1:0]      rl_n;
  logic [MW-1:0]      bit_n;
  logic [NAW-1:0]     sib;
  logic [NAW-1:0]     parent;
  logic [NAW-1:0]     left;
  logic [NAW-1:0]     right;
  logic [MW-1:0]      cand;
  logic               cand_any;
  logic [RW-1:0]      t_pick;
  logic               go_left;
  logic [NAW-1:0]     n_sel;
  logic [NAW-1:0]     blk_i;
  logic [GAW-1:0]     blk_g;
  logic               fresh;
  logic [RW-1:0]      code_b;
  logic               code_bad;
  logic [RW-1:0]      fr_d;
  logic [NAW-1:0]     fr_n;
  logic               accept;

  bba_decode #(
    .LEVELS        (LEVELS),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_decode (
    .word          (in_word),
    .base_address  (base_address),
    .managed_bytes (managed_bytes),
    .pool          (pool),
    .dec           (dec)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // tree navigation and selection
  always_comb begin
    rl_n     = pool.pspan - d;
    bit_n    = MW'(1) << rl_n;
    sib      = n[0] ? n + NAW'(1) : n - NAW'(1);
    parent   = (n - NAW'(1)) >> 1;
    left     = (n << 1) + NAW'(1);
    right    = (n << 1) + NAW'(2);
    cand     = nrd & ~((MW'(1) << rl_req) - MW'(1));
    cand_any = |cand;
    t_pick   = '0;
    for (int k = MW - 1; k >= 0; k--) begin
      if (cand[k]) t_pick = RW'(k);
    end
    go_left  = |(nrd & (MW'(1) << t_rl));
    n_sel    = go_left ? left : right;
    blk_i    = n - ((NAW'(1) << d) - NAW'(1));
    blk_g    = GAW'(blk_i) << rl_req;
    fresh    = is_alloc && (d > d_top);
    code_b   = RW'(grd) - RW'(1);
    code_bad = (grd == '0) || (code_b > pool.pspan);
    fr_d     = pool.pspan - code_b;
    fr_n     = ((NAW'(1) << fr_d) - NAW'(1)) + NAW'(g_idx >> code_b);
  end

  // memory port control
  always_comb begin
    n_re    = 1'b0;
    n_raddr = '0;
    n_we    = 1'b0;
    n_waddr = n;
    n_wdata = '0;
    g_re    = 1'b0;
    g_raddr = dec.free_off[MIN_LOG +: GAW];
    g_we    = 1'b0;
    g_waddr = g_idx;
    g_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        n_we    = 1'b1;
        n_waddr = cnt;
        n_wdata = (cnt == '0 && pool.ok) ? (MW'(1) << pool.pspan) : '0;
        g_we    = 1'b1;
        g_waddr = cnt[GAW-1:0];
      end
      S_IDLE: begin
        n_re = 1'b1;
        g_re = 1'b1;
      end
      S_PICK: begin
        // left child of the root
        if (cand_any && t_pick != pool.pspan) begin
          n_re    = 1'b1;
          n_raddr = NAW'(1);
        end
      end
      S_DSEL: begin
        if (d + RW'(1) != d_top) begin
          n_re    = 1'b1;
          n_raddr = (n_sel << 1) + NAW'(1);
        end
      end
      S_SPLIT: begin
        if (d == d_blk) begin
          g_we    = 1'b1;
          g_waddr = blk_g;
          g_wdata = CW'(rl_req) + CW'(1);
        end
      end
      S_GCHK: begin
        g_we = !code_bad;
      end
      S_MRG: begin
        n_we = 1'b1;
        if (d != '0) begin
          n_re    = 1'b1;
          n_raddr = sib;
        end
      end
      S_MRGR: begin
        if (|(nrd & bit_n)) begin
          n_we    = 1'b1;
          n_waddr = sib;
        end
      end
      S_ASC: begin
        n_we    = 1'b1;
        n_wdata = m;
        if (d != '0) begin
          n_re    = 1'b1;
          n_raddr = sib;
        end
      end
      S_ASCR: begin
        if (fresh) begin
          n_we    = 1'b1;
          n_waddr = sib;
          n_wdata = bit_n;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // node mask memory
  logic [MW-1:0] node_mem [NODES];
  always_ff @(posedge clk) begin
    if (n_we) node_mem[n_waddr] <= n_wdata;
    if (n_re) nrd <= node_mem[n_raddr];
  end

  // granule level table
  logic [CW-1:0] gran_mem [GRANULES];
  always_ff @(posedge clk) begin
    if (g_we) gran_mem[g_waddr] <= g_wdata;
    if (g_re) grd <= gran_mem[g_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= NAW'(NODES - 1);
      used          <= '0;
      base_address  <= '0;
      managed_bytes <= 16'hFFFF;
      out_valid     <= 1'b0;
    end else begin
      // a taken output word leaves unless a new one replaces it
      if (out_valid && !out_stall && (state != S_DONE || cfg_write_enable)) out_valid <= 1'b0;
      if (cfg_write_enable) begin
        // configuration write restarts the clearing pass
        if (cfg_index == bba_pkg::CFG_BASE) base_address <= cfg_data;
        else managed_bytes <= cfg_data[15:0];
        state <= S_CLEAR;
        cnt   <= NAW'(NODES - 1);
        used  <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            if (cnt == '0) state <= S_IDLE;
            else cnt <= cnt - NAW'(1);
          end
          S_IDLE: begin
            if (accept) begin
              is_alloc <= (in_word.opcode == bba_pkg::OP_ALLOC);
              addr     <= '0;
              g_idx    <= dec.free_off[MIN_LOG +: GAW];
              if (in_word.opcode == bba_pkg::OP_ALLOC) begin
                rl_req <= dec.alloc_rl;
                d_blk  <= pool.pspan - dec.alloc_rl;
                if (dec.alloc_fail) begin
                  status <= bba_pkg::ST_NO_BLOCK;
                  state  <= S_DONE;
                end else begin
                  state <= S_PICK;
                end
              end else begin
                if (dec.free_bad) begin
                  status <= bba_pkg::ST_IGNORED;
                  state  <= S_DONE;
                end else begin
                  state <= S_GCHK;
                end
              end
            end
          end
          S_PICK: begin
            n <= '0;
            d <= '0;
            t_rl  <= t_pick;
            d_top <= pool.pspan - t_pick;
            if (!cand_any) begin
              status <= bba_pkg::ST_NO_BLOCK;
              state  <= S_DONE;
            end else if (t_pick == pool.pspan) begin
              state <= S_SPLIT;
            end else begin
              state <= S_DSEL;
            end
          end
          S_DSEL: begin
            n <= n_sel;
            d <= d + RW'(1);
            if (d + RW'(1) == d_top) state <= S_SPLIT;
          end
          S_SPLIT: begin
            if (d != d_blk) begin
              n <= left;
              d <= d + RW'(1);
            end else begin
              addr   <= base_address + 32'({blk_g, {MIN_LOG{1'b0}}}) + 32'(HEADER_BYTES);
              used   <= used + (16'd1 << ({1'b0, rl_req} + 5'(MIN_LOG)));
              status <= bba_pkg::ST_DONE;
              m      <= '0;
              state  <= S_ASC;
            end
          end
          S_ASC: begin
            if (d == '0) state <= S_DONE;
            else state <= S_ASCR;
          end
          S_ASCR: begin
            m     <= m | (fresh ? bit_n : nrd);
            n     <= parent;
            d     <= d - RW'(1);
            state <= S_ASC;
          end
          S_GCHK: begin
            if (code_bad) begin
              status <= bba_pkg::ST_IGNORED;
              state  <= S_DONE;
            end else begin
              used   <= used - (16'd1 << ({1'b0, code_b} + 5'(MIN_LOG)));
              status <= bba_pkg::ST_DONE;
              n      <= fr_n;
              d      <= fr_d;
              state  <= S_MRG;
            end
          end
          S_MRG: begin
            if (d == '0) begin
              m     <= bit_n;
              state <= S_ASC;
            end else begin
              state <= S_MRGR;
            end
          end
          S_MRGR: begin
            if (|(nrd & bit_n)) begin
              n     <= parent;
              d     <= d - RW'(1);
              state <= S_MRG;
            end else begin
              m     <= bit_n;
              state <= S_ASC;
            end
          end
          S_DONE: begin
            if (!out_valid || !out_stall) begin
              out_valid              <= 1'b1;
              out_word.status        <= status;
              out_word.block_address <= addr;
              out_word.used_bytes    <= used;
              out_word.free_bytes    <= managed_bytes - used;
              state                  <= S_IDLE;
            end
          end
          default: state <= S_CLEAR;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // node memory never reads and writes the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (n_we && n_re) |-> (n_waddr != n_raddr))
    else $error("node memory read and write hit the same entry");

  // allocated bytes never exceed the largest pool
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= 16'(32'd1 << TOP_LOG))
    else $error("used byte count above pool size");

  // a finished result waits while the output word is still stalled
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall && !cfg_write_enable) |=> (state == S_DONE))
    else $error("result overwrote a pending output word");
`endif

endmodule

>>> hw/rtl/bba_decode.sv
// bba_decode: pool geometry and request decode (level rounding, free address checks)
// depends on bba_pkg
module bba_decode #(
  parameter int LEVELS       = 16,
  parameter int HEADER_BYTES = 16
) (
  input  bba_pkg::in_word_t word,
  input  logic [31:0]       base_address,
  input  logic [15:0]       managed_bytes,
  output bba_pkg::pool_t    pool,
  output bba_pkg::dec_t     dec
);

  localparam int RW      = bba_pkg::RL_W;
  localparam int MIN_LOG = $clog2(HEADER_BYTES);
  localparam int TOP_LOG = (LEVELS - 1 < 15) ? LEVELS - 1 : 15;

  logic [4:0]    size_msb;
  logic [RW-1:0] plog;
  logic [16:0]   need;
  logic [16:0]   need_m1;
  logic [4:0]    lvl;
  logic [31:0]   rel;
  logic [15:0]   off;

  // pool size: largest power of two not above the managed byte count, capped
  always_comb begin
    size_msb   = bba_pkg::msb32({16'b0, managed_bytes});
    plog       = (size_msb > 5'(TOP_LOG)) ? RW'(TOP_LOG) : size_msb[RW-1:0];
    pool.ok    = (managed_bytes != 16'd0) && (plog >= RW'(MIN_LOG));
    pool.plog  = plog;
    pool.pspan = plog - RW'(MIN_LOG);
  end

  // allocation: round size plus header up to a level
  always_comb begin
    need    = {1'b0, word.request_size} + 17'(HEADER_BYTES);
    need_m1 = need - 17'd1;
    lvl     = bba_pkg::msb32({15'b0, need_m1}) + 5'd1;
    if (lvl < 5'(MIN_LOG)) lvl = 5'(MIN_LOG);
    dec.alloc_fail = !pool.ok || (lvl > {1'b0, plog});
    dec.alloc_rl   = RW'(lvl - 5'(MIN_LOG));
  end

  // free: range, alignment and pool checks
  always_comb begin
    rel = word.free_address - base_address;
    off = rel[15:0] - 16'(HEADER_BYTES);
    dec.free_bad = (word.free_address == 32'd0) || (rel >= {16'b0, managed_bytes}) ||
                   (rel < 32'(HEADER_BYTES)) || !pool.ok ||
                   ((off >> plog) != 16'd0) || (off[MIN_LOG-1:0] != '0);
    dec.free_off = off;
  end

endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for buddy_block_allocator_core with its own allocator predictor
// depends on bba_pkg and the buddy_block_allocator_core rtl
`timescale 1ns / 100ps

module testbench;

  localparam int LEVELS       = 16;
  localparam int HEADER_BYTES = 16;
  localparam int MIN_LOG      = 4;
  localparam int TOP_LOG      = 15;
  localparam int SPAN         = TOP_LOG - MIN_LOG;
  localparam int GRANULES     = 1 << SPAN;
  localparam int NODES        = (2 << SPAN) - 1;
  localparam int WATCHDOG     = 60000;
  localparam int SETTLE       = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic cfg_index = bba_pkg::CFG_BASE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  bba_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bba_pkg::out_word_t out_word;

  buddy_block_allocator_core #(.LEVELS(LEVELS), .HEADER_BYTES(HEADER_BYTES)) dut (
    .clk(clk), .rst(rst), .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #6 clk = ~clk;

  // allocator shadow state
  logic [31:0] pool_base;
  logic [15:0] pool_bytes;
  bit          node_free [NODES];
  logic [3:0]  granule_code [GRANULES];
  int unsigned used_count;
  int          pool_log;

  bba_pkg::in_word_t  pending_words[$];
  bba_pkg::out_word_t expected_words[$];
  logic [31:0] live_addrs[$];
  int          error_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  function automatic int node_of(int depth, int idx);
    int n;
    n = (1 << depth) - 1 + idx;
    return (n < NODES) ? n : 0;
  endfunction

  function automatic void reset_pool();
    int v;
    v = pool_bytes;
    foreach (node_free[k]) node_free[k] = 0;
    foreach (granule_code[k]) granule_code[k] = '0;
    used_count = 0;
    pool_log = -1;
    while (v != 0) begin
      pool_log++;
      v = v >> 1;
    end
    if (pool_log > TOP_LOG) pool_log = TOP_LOG;
    if (pool_log >= MIN_LOG) node_free[0] = 1;
  endfunction

  function automatic bba_pkg::out_word_t make_result(logic [1:0] st, logic [31:0] addr);
    bba_pkg::out_word_t r;
    r.status = st;
    r.block_address = addr;
    r.used_bytes = 16'(used_count);
    r.free_bytes = 16'(pool_bytes - used_count);
    return r;
  endfunction

  // allocation: smallest free level, lowest address, split keeping the low half
  function automatic bba_pkg::out_word_t allocate_block(logic [15:0] req);
    int unsigned want, idx, offs;
    int lvl, lv, d;
    bit hit;
    want = req + HEADER_BYTES;
    lvl = 0;
    hit = 0;
    idx = 0;
    d = -1;
    while (lvl < 31 && (1 << lvl) < want) lvl++;
    if (lvl < MIN_LOG) lvl = MIN_LOG;
    if (pool_log < MIN_LOG || lvl > pool_log) return make_result(bba_pkg::ST_NO_BLOCK, '0);
    for (lv = lvl; lv <= pool_log && !hit; lv++) begin
      d = pool_log - lv;
      for (idx = 0; idx < (1 << d); idx++) begin
        if (node_free[node_of(d, idx)]) begin
          hit = 1;
          break;
        end
      end
    end
    if (!hit) return make_result(bba_pkg::ST_NO_BLOCK, '0);
    node_free[node_of(d, idx)] = 0;
    while (d < pool_log - lvl) begin
      d++;
      idx = idx << 1;
      node_free[node_of(d, idx + 1)] = 1;
    end
    offs = idx << lvl;
    granule_code[(offs >> MIN_LOG) & (GRANULES - 1)] = 4'(lvl - MIN_LOG + 1);
    used_count += (1 << lvl);
    return make_result(bba_pkg::ST_DONE, pool_base + offs + HEADER_BYTES);
  endfunction

  // release with repeated buddy merging
  function automatic bba_pkg::out_word_t release_block(logic [31:0] addr);
    logic [31:0] rel;
    int unsigned offs, g, idx;
    int code, lvl, d;
    rel = addr - pool_base;
    if (addr == 0 || rel >= pool_bytes || rel < HEADER_BYTES || pool_log < MIN_LOG)
      return make_result(bba_pkg::ST_IGNORED, '0);
    offs = rel - HEADER_BYTES;
    if (offs >= (1 << pool_log) || (offs & ((1 << MIN_LOG) - 1)) != 0)
      return make_result(bba_pkg::ST_IGNORED, '0);
    g = (offs >> MIN_LOG) & (GRANULES - 1);
    code = granule_code[g];
    lvl = code - 1 + MIN_LOG;
    if (code == 0 || lvl > pool_log) return make_result(bba_pkg::ST_IGNORED, '0);
    granule_code[g] = '0;
    used_count -= (1 << lvl);
    d = pool_log - lvl;
    idx = offs >> lvl;
    while (d > 0 && node_free[node_of(d, idx ^ 1)]) begin
      node_free[node_of(d, idx ^ 1)] = 0;
      idx = idx >> 1;
      d--;
    end
    node_free[node_of(d, idx)] = 1;
    return make_result(bba_pkg::ST_DONE, '0);
  endfunction

  // driver: next word from the queue, held while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          if (in_word.opcode == bba_pkg::OP_ALLOC)
            expected_words.push_back(allocate_block(in_word.request_size));
          else
            expected_words.push_back(release_block(in_word.free_address));
        end
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word, track live addresses, drive stall
  always @(posedge clk) begin
    bba_pkg::out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word %p", $realtime, out_word);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_word !== want) begin
            $display("%0t mismatch expected %p actual %p", $realtime, want, out_word);
            error_count++;
          end
          if (want.status == bba_pkg::ST_DONE && want.block_address != 0)
            live_addrs.push_back(want.block_address);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
        $display("[buddy_block_allocator_core] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    if (idx == bba_pkg::CFG_BASE) pool_base = value;
    else pool_bytes = value[15:0];
    reset_pool();
  endtask

  function automatic bba_pkg::in_word_t alloc_word(logic [15:0] sz);
    bba_pkg::in_word_t w;
    w = '0;
    w.opcode = bba_pkg::OP_ALLOC;
    w.request_size = sz;
    w.free_address = $urandom();
    return w;
  endfunction

  function automatic bba_pkg::in_word_t free_word(logic [31:0] a);
    bba_pkg::in_word_t w;
    w = '0;
    w.opcode = bba_pkg::OP_FREE;
    w.free_address = a;
    w.request_size = $urandom();
    return w;
  endfunction

  // random mix: mostly frees of live blocks and small allocations
  task automatic queue_random(int count);
    int pick, k;
    logic [31:0] a;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        pending_words.push_back(alloc_word(16'($urandom_range(0, 1) ?
          $urandom_range(0, 200) : $urandom_range(0, 4000))));
      end else if (pick < 43) begin
        pending_words.push_back(alloc_word(16'($urandom())));
      end else if (pick < 85 && live_addrs.size() > 0) begin
        pick = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[pick];
        live_addrs.delete(pick);
        pending_words.push_back(free_word(a));
      end else if (pick < 92) begin
        pending_words.push_back(free_word(pool_base + 32'($urandom_range(0, 40000))));
      end else begin
        pending_words.push_back(free_word($urandom()));
      end
      if (pending_words.size() > 8) wait (pending_words.size() < 4);
    end
  endtask

  initial begin
    pool_base = '0;
    pool_bytes = 16'd65535;
    reset_pool();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases
    pending_words.push_back(alloc_word(16'd0));
    pending_words.push_back(alloc_word(16'd1));
    pending_words.push_back(alloc_word(16'hFFFF));
    pending_words.push_back(alloc_word(16'd32752));
    pending_words.push_back(free_word(32'd0));
    pending_words.push_back(free_word(32'hFFFF_FFFF));
    pending_words.push_back(free_word(32'd16));
    pending_words.push_back(free_word(32'd16));
    pending_words.push_back(free_word(32'd24));
    pending_words.push_back(free_word(32'd8));
    pending_words.push_back(free_word(32'd48));
    pending_words.push_back(alloc_word(16'd100));
    pending_words.push_back(alloc_word(16'd32752));
    wait_drained();

    // address wrap near the top of the address space, small pool
    write_reg(bba_pkg::CFG_BASE, 32'hFFFF_FFF0);
    write_reg(bba_pkg::CFG_SIZE, 32'd100);
    pending_words.push_back(alloc_word(16'd0));
    pending_words.push_back(alloc_word(16'd0));
    pending_words.push_back(free_word(32'h0000_0000));
    pending_words.push_back(free_word(32'h0000_0010));
    pending_words.push_back(alloc_word(16'd200));
    wait_drained();

    // tiny pools
    write_reg(bba_pkg::CFG_SIZE, 32'd15);
    pending_words.push_back(alloc_word(16'd0));
    pending_words.push_back(free_word(32'hFFFF_FFF0 + 32'd16));
    wait_drained();
    write_reg(bba_pkg::CFG_SIZE, 32'd1);
    pending_words.push_back(alloc_word(16'd0));
    wait_drained();

    // phases through settings and idle profiles
    for (int ph = 0; ph < 6; ph++) begin
      live_addrs.delete();
      write_reg(bba_pkg::CFG_BASE, (ph == 5) ? 32'hFFFF_F000 : $urandom());
      write_reg(bba_pkg::CFG_SIZE, (ph == 0) ? 32'd65535 : (ph == 1) ? 32'd16 :
                (ph == 2) ? 32'd32768 : $urandom_range(1, 65535));
      case (ph)
        1: begin idle_pct = 80; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 80; end
        3: begin idle_pct = 25; stall_pct = 25; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      // long receiver hold once the clearing pass is over, so the block fills up
      if (ph == 4) begin
        repeat (NODES + 20) @(posedge clk);
        hold_cycles = 600;
      end
      queue_random(ph == 1 ? 100 : 360);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("[buddy_block_allocator_core] OK");
    end else begin
      $display("[buddy_block_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
